// ===== sv/xcrc_pkg.sv =====
// xcrc_pkg: types, protocol codes and the CRC-16 step for the XMODEM-CRC receiver.
// No dependencies; used by xmodem_crc_receiver_core.
package xcrc_pkg;

    // Input word: one receiver event
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
    } in_word_t;

    // Output word: one result
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [21:0] word_address;
        logic [31:0] word_data;
        logic        finished_ok;
        logic [23:0] total_bytes;
        logic        last;
    } out_word_t;

    // Event codes
    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_BYTE    = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_WORD = 2'd1;
    localparam logic [1:0] KIND_FIN  = 2'd2;

    // Link characters
    localparam logic [7:0] CH_C   = 8'h43;
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;

    // Packet layout (byte positions)
    localparam logic [7:0] POS_BLK    = 8'd1;
    localparam logic [7:0] POS_NBLK   = 8'd2;
    localparam logic [7:0] POS_DATA   = 8'd3;
    localparam logic [7:0] POS_CRC_HI = 8'd131;
    localparam logic [7:0] POS_CRC_LO = 8'd132;

    localparam int unsigned PAYLOAD_BYTES = 128;
    localparam int unsigned PAYLOAD_WORDS = 32;
    localparam int unsigned WIDX_W        = 5;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // CRC-16/XMODEM, one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== sv/xmodem_crc_receiver_core.sv =====
// xmodem_crc_receiver_core: XMODEM-CRC receive protocol engine with a 32-word payload memory.
// Depends on xcrc_pkg (word types, codes, CRC step).
// Usage:
//   in channel  (in_valid/in_ready/in_word): one event word per transfer - start,
//     received byte, or receive timeout.
//   out channel (out_valid/out_ready/out_word): result words - a byte to send
//     back ('C', ACK, NAK), a payload word write, or transfer finished. The
//     last result caused by an event has out_word.last set.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes buffer_size; always ready.
// The result words of an event are loaded into the output register from S_TX, S_FIN
//   or S_WORD; a payload burst first passes S_RD for the memory read.
// An event that yields no result (most packet bytes) is taken one per cycle,
//   back to back, even while a result waits in the output register.
//   An event with results holds off the next event until its final result is
//   loaded into the output register.
// A good packet that fits buffer_size drains its 32 words, each through S_RD
//   (memory read) and then S_WORD (load), then loads the ACK.
// Reset: idle, no transfer active, buffer_size all ones, output empty. The
//   payload memory is not cleared; every word is rewritten before it is read.
// A stalled receiver holds the output word; sequencing pauses until it frees.
module xmodem_crc_receiver_core #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  xcrc_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output xcrc_pkg::out_word_t out_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [23:0]         cfg_data
);

    localparam int SUM_W = COUNT_WIDTH + 1;
    localparam int CMP_W = (SUM_W > 24) ? SUM_W : 24;

    typedef enum logic [2:0] {S_IN, S_TX, S_FIN, S_RD, S_WORD} state_t;

    // Registers
    state_t                            state_reg, state_next;
    logic                              active_reg, active_next;
    logic [7:0]                        pos_reg, pos_next;
    logic [7:0]                        exp_reg, exp_next;
    logic                              good_reg, good_next;
    logic [15:0]                       crc_reg, crc_next;
    logic [7:0]                        crc_hi_reg, crc_hi_next;
    logic [COUNT_WIDTH-1:0]            count_reg, count_next;
    logic [23:0]                       bufsize_reg, bufsize_next;
    logic [7:0]                        tx_sel_reg, tx_sel_next;
    logic                              fin_after_reg, fin_after_next;
    logic                              ok_reg, ok_next;
    logic [21:0]                       base_reg, base_next;
    logic [xcrc_pkg::WIDX_W-1:0]       ridx_reg, ridx_next;
    logic                              out_valid_reg, out_valid_next;
    xcrc_pkg::out_word_t               out_reg, out_next;
    logic [23:0]                       asm_reg, asm_next;

    // Payload memory and its ports
    logic [31:0]                       payload_mem [xcrc_pkg::PAYLOAD_WORDS];
    logic [31:0]                       mem_q_reg;
    logic                              mem_we;
    logic [xcrc_pkg::WIDX_W-1:0]       mem_waddr;
    logic [31:0]                       mem_wdata;

    // Combinational helpers
    logic                              out_free;
    logic                              load;
    xcrc_pkg::out_word_t               load_word;
    logic [7:0]                        didx;
    logic [SUM_W-1:0]                  sum;
    logic                              fits;
    logic [15:0]                       rx_crc;

    assign in_ready  = (state_reg == S_IN);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign didx     = pos_reg - xcrc_pkg::POS_DATA;
    assign sum      = {1'b0, count_reg} + SUM_W'(xcrc_pkg::PAYLOAD_BYTES);
    assign fits     = CMP_W'(sum) <= CMP_W'(bufsize_reg);
    assign rx_crc   = {crc_hi_reg, in_word.rx_byte};

    // Event decode and result sequencing
    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        pos_next       = pos_reg;
        exp_next       = exp_reg;
        good_next      = good_reg;
        crc_next       = crc_reg;
        crc_hi_next    = crc_hi_reg;
        count_next     = count_reg;
        bufsize_next   = cfg_valid ? cfg_data : bufsize_reg;
        tx_sel_next    = tx_sel_reg;
        fin_after_next = fin_after_reg;
        ok_next        = ok_reg;
        base_next      = base_reg;
        ridx_next      = ridx_reg;
        asm_next       = asm_reg;
        mem_we         = 1'b0;
        mem_waddr      = didx[6:2];
        mem_wdata      = {in_word.rx_byte, asm_reg};
        load           = 1'b0;
        load_word      = '0;

        unique case (state_reg)
            S_IN:
            begin
                if (in_valid)
                begin
                    case (in_word.action)
                        xcrc_pkg::ACT_START:
                        begin
                            active_next    = 1'b1;
                            pos_next       = '0;
                            exp_next       = 8'd1;
                            good_next      = 1'b0;
                            crc_next       = '0;
                            crc_hi_next    = '0;
                            count_next     = '0;
                            tx_sel_next    = xcrc_pkg::CH_C;
                            fin_after_next = 1'b0;
                            state_next     = S_TX;
                        end
                        xcrc_pkg::ACT_TIMEOUT:
                        begin
                            if (active_reg)
                            begin
                                if (pos_reg == '0)
                                begin
                                    ok_next     = 1'b0;
                                    active_next = 1'b0;
                                    state_next  = S_FIN;
                                end
                                else
                                begin
                                    tx_sel_next    = xcrc_pkg::CH_NAK;
                                    fin_after_next = 1'b0;
                                    pos_next       = '0;
                                    state_next     = S_TX;
                                end
                            end
                        end
                        xcrc_pkg::ACT_BYTE:
                        begin
                            if (active_reg)
                            begin
                                if (pos_reg == '0)
                                begin
                                    if (in_word.rx_byte == xcrc_pkg::CH_EOT)
                                    begin
                                        tx_sel_next    = xcrc_pkg::CH_ACK;
                                        fin_after_next = 1'b1;
                                        ok_next        = 1'b1;
                                        active_next    = 1'b0;
                                        state_next     = S_TX;
                                    end
                                    else
                                    begin
                                        good_next = (in_word.rx_byte == xcrc_pkg::CH_SOH);
                                        crc_next  = '0;
                                        pos_next  = xcrc_pkg::POS_BLK;
                                    end
                                end
                                else if (pos_reg == xcrc_pkg::POS_BLK)
                                begin
                                    good_next = good_reg && (in_word.rx_byte == exp_reg);
                                    pos_next  = xcrc_pkg::POS_NBLK;
                                end
                                else if (pos_reg == xcrc_pkg::POS_NBLK)
                                begin
                                    good_next = good_reg && (in_word.rx_byte == ~exp_reg);
                                    pos_next  = xcrc_pkg::POS_DATA;
                                end
                                else if (pos_reg < xcrc_pkg::POS_CRC_HI)
                                begin
                                    // Payload byte: assemble word, write when complete
                                    crc_next = xcrc_pkg::crc_byte(crc_reg, in_word.rx_byte);
                                    case (didx[1:0])
                                        2'd0:    asm_next[7:0]   = in_word.rx_byte;
                                        2'd1:    asm_next[15:8]  = in_word.rx_byte;
                                        2'd2:    asm_next[23:16] = in_word.rx_byte;
                                        default: mem_we          = 1'b1;
                                    endcase
                                    pos_next = pos_reg + 8'd1;
                                end
                                else if (pos_reg == xcrc_pkg::POS_CRC_HI)
                                begin
                                    crc_hi_next = in_word.rx_byte;
                                    pos_next    = xcrc_pkg::POS_CRC_LO;
                                end
                                else
                                begin
                                    // Packet end: check and plan the response
                                    fin_after_next = 1'b0;
                                    if (good_reg && (rx_crc == crc_reg))
                                    begin
                                        count_next = sum[COUNT_WIDTH] ? '1 :
                                                     sum[COUNT_WIDTH-1:0];
                                        base_next  = 22'(count_reg >> 2);
                                        exp_next   = exp_reg + 8'd1;
                                        tx_sel_next = xcrc_pkg::CH_ACK;
                                        if (fits)
                                        begin
                                            ridx_next  = '0;
                                            state_next = S_RD;
                                        end
                                        else
                                        begin
                                            state_next = S_TX;
                                        end
                                    end
                                    else
                                    begin
                                        tx_sel_next = xcrc_pkg::CH_NAK;
                                        state_next  = S_TX;
                                    end
                                    pos_next = '0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_TX:
            begin
                if (out_free)
                begin
                    load              = 1'b1;
                    load_word.kind    = xcrc_pkg::KIND_SEND;
                    load_word.tx_byte = tx_sel_reg;
                    load_word.last    = !fin_after_reg;
                    state_next        = fin_after_reg ? S_FIN : S_IN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    load                  = 1'b1;
                    load_word.kind        = xcrc_pkg::KIND_FIN;
                    load_word.finished_ok = ok_reg;
                    load_word.total_bytes = 24'(count_reg);
                    load_word.last        = 1'b1;
                    state_next            = S_IN;
                end
            end
            S_RD:
            begin
                // Memory read of ridx in flight
                state_next = S_WORD;
            end
            S_WORD:
            begin
                if (out_free)
                begin
                    load                   = 1'b1;
                    load_word.kind         = xcrc_pkg::KIND_WORD;
                    load_word.word_address = base_reg + 22'(ridx_reg);
                    load_word.word_data    = mem_q_reg;
                    if (&ridx_reg)
                    begin
                        fin_after_next = 1'b0;
                        state_next     = S_TX;
                    end
                    else
                    begin
                        ridx_next  = ridx_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            default: state_next = S_IN;
        endcase

        // Output register
        out_next       = load ? load_word : out_reg;
        out_valid_next = load ? 1'b1 : (out_valid_reg && !out_ready);
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IN;
            active_reg    <= 1'b0;
            pos_reg       <= '0;
            exp_reg       <= 8'd1;
            good_reg      <= 1'b0;
            crc_reg       <= '0;
            crc_hi_reg    <= '0;
            count_reg     <= '0;
            bufsize_reg   <= '1;
            tx_sel_reg    <= '0;
            fin_after_reg <= 1'b0;
            ok_reg        <= 1'b0;
            ridx_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            pos_reg       <= pos_next;
            exp_reg       <= exp_next;
            good_reg      <= good_next;
            crc_reg       <= crc_next;
            crc_hi_reg    <= crc_hi_next;
            count_reg     <= count_next;
            bufsize_reg   <= bufsize_next;
            tx_sel_reg    <= tx_sel_next;
            fin_after_reg <= fin_after_next;
            ok_reg        <= ok_next;
            ridx_reg      <= ridx_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        asm_reg  <= asm_next;
    end

    // Payload memory: writes only while taking bytes; the read port reads ridx at all
    // times, but its data is used only in the burst, when no write happens
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            payload_mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= payload_mem[ridx_reg];
    end

    // Checks
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= xcrc_pkg::POS_CRC_LO)
        else $error("packet position out of range");

    a_idle_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> pos_reg == '0)
        else $error("inactive receiver not at packet boundary");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WORD |-> ($past(state_reg) == S_RD || $past(state_reg) == S_WORD))
        else $error("word emitted without memory read");

    a_word_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == xcrc_pkg::KIND_WORD) |-> !out_reg.last)
        else $error("payload word marked last");

    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == xcrc_pkg::KIND_FIN) |-> out_reg.last)
        else $error("finish result not marked last");

endmodule

// ===== tb/sv/xmodem_crc_receiver_core_tb.sv =====
// xmodem_crc_receiver_core_tb: self-checking bench for the XMODEM-CRC receive core.
// Feeds link events in random bursts and checks every result word against a
// behavioral model held here. Depends on xcrc_pkg and xmodem_crc_receiver_core.
module xmodem_crc_receiver_core_tb;

    localparam int CNT_W = 24;
    localparam longint unsigned COUNT_CAP = (64'd1 << CNT_W) - 1;
    // Action code the block ignores
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef enum int {
        PKT_GOOD, PKT_BAD_HDR, PKT_BAD_BLK, PKT_BAD_CPL, PKT_BAD_CRC, PKT_SHORT
    } pkt_flaw_t;
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_EOT} fill_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    xcrc_pkg::in_word_t  in_word = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    xcrc_pkg::out_word_t out_word;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [23:0]         cfg_data = '0;

    // Event words waiting to be sent, result words waiting to arrive
    xcrc_pkg::in_word_t  pending_events[$];
    xcrc_pkg::out_word_t expected_replies[$];

    // Receiver state as predicted
    logic            rx_active;
    logic [7:0]      rx_pos;
    logic [7:0]      rx_blk_exp;
    logic            rx_fields_ok;
    logic [15:0]     rx_crc;
    logic [7:0]      rx_crc_hi;
    longint unsigned rx_count;
    logic [23:0]     rx_buf_limit;
    logic [31:0]     rx_payload [xcrc_pkg::PAYLOAD_WORDS];

    // Run statistics
    int mismatches = 0;
    int events_sent = 0;
    int replies_checked = 0;
    int words_checked = 0;
    int packets_acked = 0;
    int cfg_writes = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    xmodem_crc_receiver_core #(
        .COUNT_WIDTH(CNT_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // CRC-16, polynomial 0x1021, one byte fed MSB first
    function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0} ^ (fb ? xcrc_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic xcrc_pkg::out_word_t reply(logic [1:0] kind, logic [7:0] tx,
                                                  logic [21:0] addr, logic [31:0] data,
                                                  logic ok, logic [23:0] total);
        xcrc_pkg::out_word_t r;
        r.kind         = kind;
        r.tx_byte      = tx;
        r.word_address = addr;
        r.word_data    = data;
        r.finished_ok  = ok;
        r.total_bytes  = total;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic string fmt_reply(xcrc_pkg::out_word_t r);
        return $sformatf("kind=%0d tx=%02h addr=%0d data=%08h ok=%0b total=%0d last=%0b",
                         r.kind, r.tx_byte, r.word_address, r.word_data, r.finished_ok,
                         r.total_bytes, r.last);
    endfunction

    task automatic clear_receiver_state();
        rx_active    = 1'b0;
        rx_pos       = 8'd0;
        rx_blk_exp   = 8'd1;
        rx_fields_ok = 1'b0;
        rx_crc       = 16'h0000;
        rx_crc_hi    = 8'h00;
        rx_count     = 0;
    endtask

    // Advance the receiver by one event and queue the result words it causes
    task automatic predict_replies(xcrc_pkg::in_word_t w);
        xcrc_pkg::out_word_t res[$];
        longint unsigned     old_count;
        longint unsigned     sum;
        logic [21:0]         wa;
        int                  idx;
        case (w.action)
            xcrc_pkg::ACT_START:
            begin
                clear_receiver_state();
                rx_active = 1'b1;
                res.push_back(reply(xcrc_pkg::KIND_SEND, xcrc_pkg::CH_C, '0, '0, 1'b0, '0));
            end
            xcrc_pkg::ACT_TIMEOUT:
            begin
                if (rx_active)
                begin
                    if (rx_pos == 8'd0)
                    begin
                        res.push_back(reply(xcrc_pkg::KIND_FIN, 8'h00, '0, '0, 1'b0,
                                            rx_count[23:0]));
                        rx_active = 1'b0;
                    end
                    else
                    begin
                        res.push_back(reply(xcrc_pkg::KIND_SEND, xcrc_pkg::CH_NAK, '0, '0,
                                            1'b0, '0));
                        rx_pos = 8'd0;
                    end
                end
            end
            xcrc_pkg::ACT_BYTE:
            begin
                if (!rx_active)
                    ;
                else if (rx_pos == 8'd0)
                begin
                    if (w.rx_byte == xcrc_pkg::CH_EOT)
                    begin
                        res.push_back(reply(xcrc_pkg::KIND_SEND, xcrc_pkg::CH_ACK, '0, '0,
                                            1'b0, '0));
                        res.push_back(reply(xcrc_pkg::KIND_FIN, 8'h00, '0, '0, 1'b1,
                                            rx_count[23:0]));
                        rx_active = 1'b0;
                    end
                    else
                    begin
                        rx_fields_ok = (w.rx_byte == xcrc_pkg::CH_SOH);
                        rx_crc       = 16'h0000;
                        rx_pos       = xcrc_pkg::POS_BLK;
                    end
                end
                else if (rx_pos == xcrc_pkg::POS_BLK)
                begin
                    rx_fields_ok = rx_fields_ok && (w.rx_byte == rx_blk_exp);
                    rx_pos       = xcrc_pkg::POS_NBLK;
                end
                else if (rx_pos == xcrc_pkg::POS_NBLK)
                begin
                    rx_fields_ok = rx_fields_ok && (w.rx_byte == ~rx_blk_exp);
                    rx_pos       = xcrc_pkg::POS_DATA;
                end
                else if (rx_pos < xcrc_pkg::POS_CRC_HI)
                begin
                    // payload byte lands in its lane of the staging word
                    idx = rx_pos - xcrc_pkg::POS_DATA;
                    rx_payload[idx / 4][(idx % 4) * 8 +: 8] = w.rx_byte;
                    rx_crc = crc16_next(rx_crc, w.rx_byte);
                    rx_pos = rx_pos + 8'd1;
                end
                else if (rx_pos == xcrc_pkg::POS_CRC_HI)
                begin
                    rx_crc_hi = w.rx_byte;
                    rx_pos    = xcrc_pkg::POS_CRC_LO;
                end
                else
                begin
                    if (rx_fields_ok && {rx_crc_hi, w.rx_byte} == rx_crc)
                    begin
                        old_count = rx_count;
                        sum       = old_count + xcrc_pkg::PAYLOAD_BYTES;
                        rx_count  = (sum > COUNT_CAP) ? COUNT_CAP : sum;
                        // words only go out while the buffer can take the whole packet
                        if (sum <= rx_buf_limit)
                        begin
                            for (int k = 0; k < xcrc_pkg::PAYLOAD_WORDS; k++)
                            begin
                                wa = 22'((old_count >> 2) + k);
                                res.push_back(reply(xcrc_pkg::KIND_WORD, 8'h00, wa,
                                                    rx_payload[k], 1'b0, '0));
                            end
                        end
                        res.push_back(reply(xcrc_pkg::KIND_SEND, xcrc_pkg::CH_ACK, '0, '0,
                                            1'b0, '0));
                        rx_blk_exp = rx_blk_exp + 8'd1;
                        packets_acked++;
                    end
                    else
                        res.push_back(reply(xcrc_pkg::KIND_SEND, xcrc_pkg::CH_NAK, '0, '0,
                                            1'b0, '0));
                    rx_pos = 8'd0;
                end
            end
            default: ;
        endcase
        if (res.size() > 0)
        begin
            res[res.size() - 1].last = 1'b1;
            foreach (res[i])
                expected_replies.push_back(res[i]);
        end
    endtask

    task automatic queue_event(logic [1:0] act, logic [7:0] b);
        xcrc_pkg::in_word_t w;
        w.action  = act;
        w.rx_byte = b;
        pending_events.push_back(w);
    endtask

    // One 133-byte packet, possibly damaged or cut short by a timeout
    task automatic queue_packet(logic [7:0] blk, pkt_flaw_t flaw, fill_t fill);
        logic [7:0]  data [xcrc_pkg::PAYLOAD_BYTES];
        logic [7:0]  hdr;
        logic [7:0]  blk_b;
        logic [7:0]  nblk;
        logic [7:0]  b;
        logic [15:0] crc;
        int          cut;
        crc = 16'h0000;
        for (int i = 0; i < xcrc_pkg::PAYLOAD_BYTES; i++)
        begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                FILL_EOT:  b = xcrc_pkg::CH_EOT;
                default:   b = 8'($urandom_range(0, 255));
            endcase
            data[i] = b;
            crc = crc16_next(crc, b);
        end
        hdr   = xcrc_pkg::CH_SOH;
        blk_b = blk;
        nblk  = ~blk;
        cut   = xcrc_pkg::POS_CRC_LO + 1;
        case (flaw)
            PKT_BAD_HDR:
                do hdr = 8'($urandom_range(0, 255));
                while (hdr == xcrc_pkg::CH_SOH || hdr == xcrc_pkg::CH_EOT);
            PKT_BAD_BLK:
                blk_b = ($urandom_range(0, 1) == 0) ? blk - 8'd1
                                                    : blk ^ (8'h01 << $urandom_range(0, 7));
            PKT_BAD_CPL: nblk = nblk ^ (8'h01 << $urandom_range(0, 7));
            PKT_BAD_CRC: crc = crc ^ (16'h0001 << $urandom_range(0, 15));
            PKT_SHORT:   cut = $urandom_range(1, xcrc_pkg::POS_CRC_LO);
            default: ;
        endcase
        for (int n = 0; n < cut; n++)
        begin
            if (n == 0)
                b = hdr;
            else if (n == xcrc_pkg::POS_BLK)
                b = blk_b;
            else if (n == xcrc_pkg::POS_NBLK)
                b = nblk;
            else if (n < xcrc_pkg::POS_CRC_HI)
                b = data[n - xcrc_pkg::POS_DATA];
            else if (n == xcrc_pkg::POS_CRC_HI)
                b = crc[15:8];
            else
                b = crc[7:0];
            queue_event(xcrc_pkg::ACT_BYTE, b);
        end
        if (flaw == PKT_SHORT)
            queue_event(xcrc_pkg::ACT_TIMEOUT, 8'($urandom_range(0, 255)));
    endtask

    // A transfer: maybe a stray byte or unused event, start, a run of packets, then EOT, timeout or nothing
    task automatic queue_transfer(int n_pkts, int good_pct);
        logic [7:0] blk;
        pkt_flaw_t  flaw;
        fill_t      fill;
        int         r;
        if ($urandom_range(0, 3) == 0)
            queue_event(xcrc_pkg::ACT_BYTE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 5) == 0)
            queue_event(ACT_UNUSED, 8'($urandom_range(0, 255)));
        queue_event(xcrc_pkg::ACT_START, 8'($urandom_range(0, 255)));
        blk = 8'd1;
        for (int p = 0; p < n_pkts; p++)
        begin
            if ($urandom_range(0, 99) < good_pct)
                flaw = PKT_GOOD;
            else
                flaw = pkt_flaw_t'($urandom_range(PKT_BAD_HDR, PKT_SHORT));
            r = $urandom_range(0, 15);
            fill = (r == 0) ? FILL_ZERO : (r == 1) ? FILL_ONES :
                   (r == 2) ? FILL_EOT : FILL_RANDOM;
            queue_packet(blk, flaw, fill);
            if (flaw == PKT_GOOD)
                blk = blk + 8'd1;
            if ($urandom_range(0, 19) == 0)
                queue_event(ACT_UNUSED, 8'($urandom_range(0, 255)));
            // restart in the middle of a packet
            if ($urandom_range(0, 29) == 0)
            begin
                queue_event(xcrc_pkg::ACT_BYTE, xcrc_pkg::CH_SOH);
                queue_event(xcrc_pkg::ACT_START, 8'($urandom_range(0, 255)));
                blk = 8'd1;
            end
        end
        r = $urandom_range(0, 9);
        if (r < 7)
            queue_event(xcrc_pkg::ACT_BYTE, xcrc_pkg::CH_EOT);
        else if (r < 9)
            queue_event(xcrc_pkg::ACT_TIMEOUT, 8'($urandom_range(0, 255)));
    endtask

    task automatic write_buffer_size(logic [23:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        rx_buf_limit = v;
        cfg_writes++;
    endtask

    // Wait until every event is taken and every result has come back
    task automatic drain_to_idle();
        while (pending_events.size() != 0 || in_valid || expected_replies.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Sender: bursts of random length with random gaps, some long gapless runs
    int burst_left = 1;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        xcrc_pkg::in_word_t nxt_word;
        logic               nxt_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word  <= '0;
        end
        else
        begin
            nxt_valid = in_valid;
            nxt_word  = in_word;
            if (in_valid && in_ready)
            begin
                predict_replies(in_word);
                events_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_events.size() > 0)
                begin
                    nxt_word  = pending_events.pop_front();
                    nxt_valid = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            burst_left = $urandom_range(100, 400);
                            gap_left   = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 24);
                            gap_left   = $urandom_range(0, 6);
                        end
                    end
                end
            end
            in_valid <= nxt_valid;
            in_word  <= nxt_word;
        end
    end

    // Result checker plus receiver stall pattern
    logic [15:0] ready_pat = 16'hFFFF;
    int          pat_cycles = 0;
    always @(posedge clk or negedge rst_n)
    begin
        xcrc_pkg::out_word_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: %s", fmt_reply(out_word));
                end
                else
                begin
                    want = expected_replies.pop_front();
                    replies_checked++;
                    if (want.kind == xcrc_pkg::KIND_WORD)
                        words_checked++;
                    if (out_word !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result %0d mismatch", replies_checked);
                            $display("  expected %s", fmt_reply(want));
                            $display("  actual   %s", fmt_reply(out_word));
                        end
                    end
                end
            end
            // rotate a 16-bit ready pattern, pick a new one now and then; each new one has bit 0 set
            if (pat_cycles == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       ready_pat = 16'hFFFF;
                    1:       ready_pat = 16'($urandom_range(0, 65535)) | 16'h0001;
                    2:       ready_pat = 16'h0001 | (16'h0001 << $urandom_range(1, 15));
                    default: ready_pat = 16'($urandom_range(0, 65535) |
                                             $urandom_range(0, 65535)) | 16'h0001;
                endcase
                pat_cycles = $urandom_range(32, 200);
            end
            else
                pat_cycles--;
            ready_pat = {ready_pat[0], ready_pat[15:1]};
            out_ready <= ready_pat[0];
        end
    end

    // Stimulus phases
    initial
    begin
        clear_receiver_state();
        rx_buf_limit = 24'hFFFFFF;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        write_buffer_size(24'hFFFFFF);
        // directed: idle events, each event kind, boundary cases
        queue_event(xcrc_pkg::ACT_BYTE, 8'hFF);
        queue_event(xcrc_pkg::ACT_TIMEOUT, 8'h00);
        queue_event(ACT_UNUSED, 8'hFF);
        queue_event(xcrc_pkg::ACT_START, 8'h00);
        queue_event(ACT_UNUSED, 8'h00);
        queue_event(xcrc_pkg::ACT_TIMEOUT, 8'hFF);
        queue_event(xcrc_pkg::ACT_START, 8'hFF);
        queue_event(xcrc_pkg::ACT_BYTE, xcrc_pkg::CH_EOT);
        queue_event(xcrc_pkg::ACT_START, 8'hA5);
        queue_event(xcrc_pkg::ACT_BYTE, 8'h00);
        queue_event(xcrc_pkg::ACT_BYTE, xcrc_pkg::CH_EOT);
        queue_event(xcrc_pkg::ACT_BYTE, 8'hFF);
        queue_event(xcrc_pkg::ACT_TIMEOUT, 8'h5A);
        queue_event(xcrc_pkg::ACT_BYTE, xcrc_pkg::CH_SOH);
        queue_event(xcrc_pkg::ACT_START, 8'h00);
        queue_event(xcrc_pkg::ACT_BYTE, xcrc_pkg::CH_EOT);
        queue_event(xcrc_pkg::ACT_START, 8'h3C);
        queue_event(xcrc_pkg::ACT_TIMEOUT, 8'h00);
        drain_to_idle();

        // one full packet into a buffer that holds exactly one packet
        write_buffer_size(24'd128);
        queue_transfer(1, 100);
        drain_to_idle();
        repeat (60) @(posedge clk);

        $display("ran %0d events, %0d buffer_size writes, %0d packets acked",
                 events_sent, cfg_writes, packets_acked);
        $display("checked %0d result words, %0d of them payload writes; %0d mismatches",
                 replies_checked, words_checked, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #30000000;
        $display("timeout: %0d events still queued, %0d results outstanding",
                 pending_events.size(), expected_replies.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
